// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the checker files.
// Each macro takes a label, clock, property and message; CHK_ASSERT also takes an active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is low
`define CHK_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// Clocked assertion that is also checked during reset
`define CHK_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/tshc_pkg.sv -----
// Package for the turn signal and hazard controller.
// Holds item types, blink mode codes, command byte codes and the blink period width and reset value; no dependencies.
`default_nettype none

package tshc_pkg;

    // Blink mode codes
    typedef enum logic [1:0] {
        MODE_NONE   = 2'd0,
        MODE_LEFT   = 2'd1,
        MODE_RIGHT  = 2'd2,
        MODE_HAZARD = 2'd3
    } t_mode;

    // Item kinds
    localparam logic OP_CMD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // ASCII command bytes
    localparam logic [7:0] CMD_LEFT_ON   = 8'h4C;  // L
    localparam logic [7:0] CMD_LEFT_OFF  = 8'h6C;  // l
    localparam logic [7:0] CMD_RIGHT_ON  = 8'h52;  // R
    localparam logic [7:0] CMD_RIGHT_OFF = 8'h72;  // r
    localparam logic [7:0] CMD_HAZ_ON    = 8'h5A;  // Z
    localparam logic [7:0] CMD_HAZ_OFF   = 8'h7A;  // z
    localparam logic [7:0] CMD_HEAD_ON   = 8'h46;  // F
    localparam logic [7:0] CMD_HEAD_OFF  = 8'h66;  // f
    localparam logic [7:0] CMD_HORN_ON   = 8'h48;  // H
    localparam logic [7:0] CMD_HORN_OFF  = 8'h68;  // h

    // Blink period
    localparam int unsigned PERIOD_W = 16;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd500;

    typedef struct packed {
        logic       op;
        logic [7:0] cmd_byte;
    } t_in_item;

    typedef struct packed {
        logic       left_lamp;
        logic       right_lamp;
        logic       horn_drive;
        logic       headlight_drive;
        logic [1:0] blink_mode;
    } t_out_item;

endpackage

`default_nettype wire

// ----- rtl/tshc_core.sv -----
// Light control state and the single-pass update for one item.
// Depends on tshc_pkg for item types, mode and command codes.
`default_nettype none

module tshc_core
    import tshc_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_step,
    input  wire t_in_item            i_item,
    input  wire logic [PERIOD_W-1:0] i_period,
    output t_out_item                o_result
);

    logic [1:0]          r_turn,   n_turn;
    logic                r_haz,    n_haz;
    logic                r_head,   n_head;
    logic                r_horn,   n_horn;
    logic                r_phase,  n_phase;
    logic                r_armed,  n_armed;
    logic [PERIOD_W-1:0] r_count,  n_count;
    logic                r_left,   n_left;
    logic                r_right,  n_right;

    t_mode               mode;
    logic                do_phase;
    logic                toggled;
    logic [PERIOD_W-1:0] reload;

    // Zero period counts as one tick
    assign reload = (i_period == '0) ? {{(PERIOD_W-1){1'b0}}, 1'b1} : i_period;

    // Latch updates, then phase event or timer countdown
    always_comb begin
        n_turn   = r_turn;
        n_haz    = r_haz;
        n_head   = r_head;
        n_horn   = r_horn;
        n_phase  = r_phase;
        n_armed  = r_armed;
        n_count  = r_count;
        n_left   = r_left;
        n_right  = r_right;
        do_phase = 1'b0;

        if (i_item.op == OP_CMD) begin
            case (i_item.cmd_byte)
                CMD_LEFT_ON:   n_turn = MODE_LEFT;
                CMD_LEFT_OFF:  if (r_turn == MODE_LEFT) n_turn = MODE_NONE;
                CMD_RIGHT_ON:  n_turn = MODE_RIGHT;
                CMD_RIGHT_OFF: if (r_turn == MODE_RIGHT) n_turn = MODE_NONE;
                CMD_HAZ_ON:    n_haz  = 1'b1;
                CMD_HAZ_OFF:   n_haz  = 1'b0;
                CMD_HEAD_ON:   n_head = 1'b1;
                CMD_HEAD_OFF:  n_head = 1'b0;
                CMD_HORN_ON:   n_horn = 1'b1;
                CMD_HORN_OFF:  n_horn = 1'b0;
                default:       ;
            endcase
        end

        mode    = n_haz ? MODE_HAZARD : t_mode'(n_turn);
        toggled = ~r_phase;

        if (i_item.op == OP_CMD) begin
            if (mode != MODE_NONE) begin
                do_phase = 1'b1;
            end else begin
                n_armed = 1'b0;
                n_count = '0;
                n_left  = 1'b0;
                n_right = 1'b0;
            end
        end else if (r_armed) begin
            if (r_count <= {{(PERIOD_W-1){1'b0}}, 1'b1}) begin
                n_count  = '0;
                do_phase = 1'b1;
            end else begin
                n_count = r_count - {{(PERIOD_W-1){1'b0}}, 1'b1};
            end
        end

        // Toggle phase, drive lamps, rearm or stop the timer
        if (do_phase) begin
            n_phase = toggled;
            n_left  = toggled && (mode == MODE_LEFT  || mode == MODE_HAZARD);
            n_right = toggled && (mode == MODE_RIGHT || mode == MODE_HAZARD);
            if (mode != MODE_NONE) begin
                n_armed = 1'b1;
                n_count = reload;
            end else begin
                n_armed = 1'b0;
                n_count = '0;
            end
        end

        o_result.left_lamp       = n_left;
        o_result.right_lamp      = n_right;
        o_result.horn_drive      = n_horn;
        o_result.headlight_drive = n_head;
        o_result.blink_mode      = mode;
    end

    // Commit state when an item passes through
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_turn  <= MODE_NONE;
            r_haz   <= 1'b0;
            r_head  <= 1'b0;
            r_horn  <= 1'b0;
            r_phase <= 1'b0;
            r_armed <= 1'b0;
            r_count <= '0;
            r_left  <= 1'b0;
            r_right <= 1'b0;
        end else if (i_step) begin
            r_turn  <= n_turn;
            r_haz   <= n_haz;
            r_head  <= n_head;
            r_horn  <= n_horn;
            r_phase <= n_phase;
            r_armed <= n_armed;
            r_count <= n_count;
            r_left  <= n_left;
            r_right <= n_right;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/tshc_out_buf.sv -----
// Result register with a skid stage for the output channel.
// Depends on tshc_pkg for the result item type.
`default_nettype none

module tshc_out_buf
    import tshc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire t_out_item i_item,
    output logic           o_room,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_out_item      o_item
);

    logic      r_out_vld;
    logic      r_skid_vld;
    t_out_item r_out;
    t_out_item r_skid;
    logic      pop;

    assign pop     = r_out_vld && i_ready;
    assign o_room  = !r_skid_vld;
    assign o_valid = r_out_vld;
    assign o_item  = r_out;

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (pop) begin
                r_skid_vld <= 1'b0;
            end
        end else if (i_push) begin
            if (r_out_vld && !pop) begin
                r_skid_vld <= 1'b1;
            end else begin
                r_out_vld <= 1'b1;
            end
        end else if (pop) begin
            r_out_vld <= 1'b0;
        end
    end

    // Payload: refill from skid, else take the new item
    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (i_push) begin
            if (r_out_vld && !pop) begin
                r_skid <= i_item;
            end else begin
                r_out <= i_item;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/turn_signal_hazard_controller.sv -----
// Path: the input register feeds the state update, which writes the result
// register, with a skid stage behind it; a result is offered from there.
// Throughput: one item per cycle while the skid stage is empty.
// Reset (synchronous, active low): all latches, timer and lamps clear,
// the blink period returns to 500 ticks. Depends on tshc_pkg and submodules.
`default_nettype none

module turn_signal_hazard_controller
    import tshc_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [PERIOD_W-1:0] i_cfg_wdata,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire t_in_item            i_in_item,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output t_out_item                o_out_item
);

    logic [PERIOD_W-1:0] r_period;
    logic                r_in_vld;
    t_in_item            r_in;
    logic                buf_room;
    logic                step;
    t_out_item           result;

    assign step       = r_in_vld && buf_room;
    assign o_in_ready = !r_in_vld || buf_room;

    // Blink period register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RESET;
        end else if (i_cfg_we) begin
            r_period <= i_cfg_wdata;
        end
    end

    // Input register: hold until the item moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    tshc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_in),
        .i_period (r_period),
        .o_result (result)
    );

    tshc_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (step),
        .i_item  (result),
        .o_room  (buf_room),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_item)
    );

endmodule

`default_nettype wire

// ----- rtl/tshc_checker.sv -----
// Port-level checks for the turn signal and hazard controller.
// Depends on tshc_pkg and assert_macros.svh; bound to the top level below.
`default_nettype none
`include "assert_macros.svh"

module tshc_checker
    import tshc_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                o_in_ready,
    input wire logic                o_out_valid,
    input wire logic                i_out_ready,
    input wire t_out_item           o_out_item
);

    // Stalled result item holds
    `CHK_ASSERT(a_out_hold, i_clk, i_rst_n,
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item),
        "result item dropped or changed while stalled")

    // Input stalls only while a result is waiting
    `CHK_ASSERT(a_stall_has_result, i_clk, i_rst_n,
        !o_in_ready |-> o_out_valid,
        "input stalled with no result pending")

    // No mode means both turn lamps dark
    `CHK_ASSERT(a_dark_no_mode, i_clk, i_rst_n,
        o_out_valid && o_out_item.blink_mode == MODE_NONE
            |-> !o_out_item.left_lamp && !o_out_item.right_lamp,
        "turn lamp lit with no blink mode")

    // Single-side modes never light the opposite lamp
    `CHK_ASSERT(a_side_lamp, i_clk, i_rst_n,
        o_out_valid && (o_out_item.blink_mode == MODE_LEFT && o_out_item.right_lamp
            || o_out_item.blink_mode == MODE_RIGHT && o_out_item.left_lamp) |-> 1'b0,
        "lamp lit on the wrong side")

    // Nothing offered right after reset
    `CHK_ASSERT_ALWAYS(a_reset_idle, i_clk,
        !i_rst_n |=> !o_out_valid,
        "result offered after reset")

endmodule

bind turn_signal_hazard_controller tshc_checker u_tshc_checker (.*);

`default_nettype wire
